// ===== rtl/sas_pkg.sv =====
// Package for the sprite animation sequencer: field widths, action and register codes,
// and the frame-set descriptor type. No dependencies.
package sas_pkg;

  localparam int SET_DEPTH_DEF = 16;

  localparam int FRAME_W   = 8;
  localparam int WIDTH_W   = 16;
  localparam int MASK_W    = 24;
  localparam int TIME_W    = 32;
  localparam int TICK_W    = 16;
  localparam int DELAY_W   = 8;
  localparam int RSTD_W    = 16;
  localparam int SETIDX_W  = 4;
  localparam int NEXT_W    = 5;
  localparam int COUNT_W   = 5;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 64;

  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_SELECT = 2'd1;
  localparam logic [1:0] ACT_WRITE  = 2'd2;

  localparam logic REG_FRAME_WIDTH = 1'b0;
  localparam logic REG_SET_COUNT   = 1'b1;

  typedef struct packed {
    logic [FRAME_W-1:0] start;
    logic [FRAME_W-1:0] stop;
    logic               split;
    logic [DELAY_W-1:0] delay;
    logic [RSTD_W-1:0]  hold_time;
    logic [NEXT_W-1:0]  next_set;
  } entry_t;

endpackage

// ===== rtl/sprite_animation_sequencer_core.sv =====
// Sprite animation sequencer top level: control sequencer, descriptor memory,
// serial divider and serial multiplier. Depends on sas_pkg, sas_table, sas_div, sas_mul.
//
// Each request on the in_ channel carries an action in in_tuser: advance one tick,
// select a frame set, or write a descriptor. Every request yields exactly one result
// on the out_ channel with the shown frame, its pixel span in the sheet, the active
// set and the status flags. The cfg_ channel writes the frame width and the set count
// and is always ready; write it only while no request is in flight.
// One request is processed at a time. A tick that reaches the divider passes through
// one memory read, the bit-serial divider, an evaluation step, a multiplier start, the
// bit-serial multiplier and an output step. A tick that chains to the next set adds a
// second memory read; other requests skip the divider. The next request is accepted
// in the cycle after the result is loaded.
// The result sits in an output register, so in_tready returns high as soon as it is
// loaded even if the receiver stalls; a second result waits until the first is taken.
// A synchronous reset clears the sequencer state and the registers; descriptors are
// not cleared and must be written before a set that uses them is selected.
module sprite_animation_sequencer_core #(
  parameter int SET_DEPTH = sas_pkg::SET_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata from bit 0: now_time, set_index, entry_start, entry_end, entry_split,
  // entry_delay, entry restart hold time, entry_next_set, zero fill.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [sas_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: action.
  input  logic [1:0]                       in_tuser,
  // out_tdata from bit 0: frame_now, mask_left, mask_right, set_now, frame_changed,
  // holding, running_ok, zero fill.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [sas_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [15:0]                      cfg_data
);

  localparam int IDX_W = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int NF_W  = sas_pkg::TICK_W + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_DIV, S_EVAL, S_MST, S_MUL, S_OUT
  } state_t;

  state_t state_r;

  logic [sas_pkg::WIDTH_W-1:0]  frame_width_r;
  logic [sas_pkg::COUNT_W-1:0]  set_count_r;
  logic [sas_pkg::SETIDX_W-1:0] active_set_r;
  logic [sas_pkg::FRAME_W-1:0]  shown_r;
  logic [sas_pkg::TICK_W-1:0]   tick_r;
  logic                         hold_r;
  logic [sas_pkg::TIME_W-1:0]   release_r;
  logic                         valid_flag_r;
  logic                         changed_r;
  logic                         op_pick_r;
  logic [sas_pkg::SETIDX_W-1:0] pick_idx_r;
  logic [sas_pkg::TIME_W-1:0]   now_r;
  logic                         out_tvalid_r;
  logic [sas_pkg::OUT_DATA_W-1:0] out_tdata_r;

  logic                         in_acc;
  logic [sas_pkg::TIME_W-1:0]   in_now;
  logic [sas_pkg::SETIDX_W-1:0] in_idx;
  sas_pkg::entry_t              in_entry;
  logic                         idx_in_depth;
  logic                         idx_ok;
  logic                         next_ok;

  logic                         wr_en;
  logic                         rd_en;
  logic [IDX_W-1:0]             rd_addr;
  sas_pkg::entry_t              ent;

  logic                         still_set;
  logic                         held;
  logic [sas_pkg::TICK_W:0]     tick_sum;
  logic [sas_pkg::TICK_W-1:0]   tick_sat;
  logic [sas_pkg::DELAY_W-1:0]  divisor;
  logic                         div_start;
  logic                         div_done;
  logic [sas_pkg::TICK_W-1:0]   quotient;

  logic signed [NF_W-1:0]       nf_raw;
  logic signed [NF_W-1:0]       nf;
  logic signed [NF_W-1:0]       end_ext;
  logic                         over;

  logic                         mul_start;
  logic                         mul_done;
  logic [sas_pkg::MASK_W-1:0]   product;
  logic                         out_load;

  assign in_now          = in_tdata[31:0];
  assign in_idx          = in_tdata[35:32];
  assign in_entry.start  = in_tdata[43:36];
  assign in_entry.stop   = in_tdata[51:44];
  assign in_entry.split  = in_tdata[52];
  assign in_entry.delay  = in_tdata[60:53];
  assign in_entry.hold_time = in_tdata[76:61];
  assign in_entry.next_set  = in_tdata[81:77];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign idx_in_depth = ({28'd0, in_idx} < 32'(SET_DEPTH));
  assign idx_ok       = idx_in_depth && ({1'b0, in_idx} < set_count_r);
  assign next_ok      = !ent.next_set[4] && ({1'b0, ent.next_set[3:0]} < set_count_r) &&
                        ({28'd0, ent.next_set[3:0]} < 32'(SET_DEPTH));

  assign wr_en = in_acc && (in_tuser == sas_pkg::ACT_WRITE) && idx_in_depth;

  // Evaluation of the current tick from the descriptor held at the memory output.
  assign still_set = (ent.start == ent.stop) && ent.next_set[4];
  assign held      = hold_r && (release_r > now_r);
  assign tick_sum  = {1'b0, tick_r} + (ent.split ? 17'd2 : 17'd1);
  assign tick_sat  = tick_sum[sas_pkg::TICK_W] ? '1 : tick_sum[sas_pkg::TICK_W-1:0];
  assign divisor   = (ent.delay == '0) ? 8'd1 : ent.delay;
  assign div_start = (state_r == S_RD) && !op_pick_r && !still_set && !held;

  assign end_ext = NF_W'({10'd0, ent.stop});
  always_comb begin
    if (ent.start < ent.stop) begin
      nf_raw = NF_W'({10'd0, ent.start}) + NF_W'({2'd0, quotient});
    end else begin
      nf_raw = NF_W'({10'd0, ent.start}) - NF_W'({2'd0, quotient});
    end
    nf = (ent.split && nf_raw[0]) ? NF_W'(nf_raw - NF_W'(1)) : nf_raw;
    if (ent.start < ent.stop) begin
      over = (nf > end_ext);
    end else begin
      over = (nf < end_ext);
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = IDX_W'(active_set_r);
    if (in_acc && (in_tuser == sas_pkg::ACT_SELECT) && idx_ok) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(in_idx);
    end else if (in_acc && (in_tuser == sas_pkg::ACT_TICK) && valid_flag_r) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(active_set_r);
    end else if ((state_r == S_EVAL) && over && hold_r && next_ok) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(ent.next_set[3:0]);
    end
  end

  assign mul_start = (state_r == S_MST);
  assign out_load  = (state_r == S_OUT) && (!out_tvalid_r || out_tready);

  sas_table #(
    .SET_DEPTH (SET_DEPTH),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (IDX_W'(in_idx)),
    .wr_data (in_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ent)
  );

  sas_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (tick_sat),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  sas_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .frame   (shown_r),
    .width   (frame_width_r),
    .done    (mul_done),
    .product (product)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r <= '0;
      set_count_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sas_pkg::REG_FRAME_WIDTH: frame_width_r <= cfg_data;
        sas_pkg::REG_SET_COUNT:   set_count_r   <= cfg_data[sas_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_set_r <= '0;
      shown_r      <= '0;
      tick_r       <= '0;
      hold_r       <= 1'b0;
      release_r    <= '0;
      valid_flag_r <= 1'b0;
      changed_r    <= 1'b0;
      op_pick_r    <= 1'b0;
      pick_idx_r   <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            changed_r  <= 1'b0;
            now_r      <= in_now;
            pick_idx_r <= in_idx;
            op_pick_r  <= (in_tuser == sas_pkg::ACT_SELECT);
            if ((in_tuser == sas_pkg::ACT_SELECT) && idx_ok) begin
              state_r <= S_RD;
            end else if ((in_tuser == sas_pkg::ACT_TICK) && valid_flag_r) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_MST;
            end
          end
        end
        S_RD: begin
          if (op_pick_r) begin
            active_set_r <= pick_idx_r;
            tick_r       <= '0;
            release_r    <= '0;
            shown_r      <= ent.start;
            valid_flag_r <= 1'b1;
            changed_r    <= 1'b1;
            state_r      <= S_MST;
          end else if (still_set || held) begin
            state_r <= S_MST;
          end else begin
            tick_r  <= tick_sat;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (over) begin
            if (!hold_r) begin
              hold_r    <= 1'b1;
              release_r <= sas_pkg::TIME_W'(now_r + {16'd0, ent.hold_time});
              state_r   <= S_MST;
            end else begin
              hold_r <= 1'b0;
              if (next_ok) begin
                op_pick_r  <= 1'b1;
                pick_idx_r <= ent.next_set[3:0];
                state_r    <= S_RD;
              end else begin
                state_r <= S_MST;
              end
            end
          end else begin
            if (nf[sas_pkg::FRAME_W-1:0] != shown_r) begin
              shown_r   <= nf[sas_pkg::FRAME_W-1:0];
              changed_r <= 1'b1;
            end
            state_r <= S_MST;
          end
        end
        S_MST: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (mul_done) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {1'b0, valid_flag_r, hold_r, changed_r, active_set_r,
                      sas_pkg::MASK_W'(product + sas_pkg::MASK_W'(frame_width_r)),
                      product, shown_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide state");

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == S_MUL)
    else $error("multiplier finished outside the multiply state");

  a_hold_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hold_r) |-> $past(state_r) == S_EVAL)
    else $error("hold flag set outside tick evaluation");

  a_valid_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(valid_flag_r) |-> $past(state_r) == S_RD && $past(op_pick_r))
    else $error("running flag set without a set selection");

  a_result_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_tvalid_r && out_tdata_r[7:0] == shown_r)
    else $error("result frame does not match the shown frame");
`endif

endmodule

// ===== rtl/sas_table.sv =====
// Frame-set descriptor memory: one write port, one read port with registered data.
// Depends on sas_pkg for the descriptor type.
module sas_table #(
  parameter int SET_DEPTH = sas_pkg::SET_DEPTH_DEF,
  parameter int IDX_W     = 4
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  sas_pkg::entry_t wr_data,
  input  logic            rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output sas_pkg::entry_t rd_data
);

  sas_pkg::entry_t mem [SET_DEPTH];
  sas_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/sas_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on sas_pkg for the operand widths.
module sas_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [sas_pkg::TICK_W-1:0]   dividend,
  input  logic [sas_pkg::DELAY_W-1:0]  divisor,
  output logic                         done,
  output logic [sas_pkg::TICK_W-1:0]   quotient
);

  localparam int DVD_W = sas_pkg::TICK_W;
  localparam int DVS_W = sas_pkg::DELAY_W;
  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial = {rem_r, quo_r[DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[DVS_W-1:0];
      end
      quo_r <= {quo_r[DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/sas_mul.sv =====
// Bit-serial shift-and-add multiplier for the sheet offset of the shown frame.
// Depends on sas_pkg for the operand and product widths.
module sas_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sas_pkg::FRAME_W-1:0] frame,
  input  logic [sas_pkg::WIDTH_W-1:0] width,
  output logic                        done,
  output logic [sas_pkg::MASK_W-1:0]  product
);

  localparam int MLR_W = sas_pkg::FRAME_W;
  localparam int PRD_W = sas_pkg::MASK_W;
  localparam int CNT_W = $clog2(MLR_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [MLR_W-1:0] mlr_r;
  logic [PRD_W-1:0] acc_r;
  logic [PRD_W-1:0] addend;

  assign addend = mlr_r[MLR_W-1] ? PRD_W'(width) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MLR_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mlr_r <= frame;
      acc_r <= '0;
    end else if (busy_r) begin
      mlr_r <= {mlr_r[MLR_W-2:0], 1'b0};
      acc_r <= PRD_W'({acc_r[PRD_W-2:0], 1'b0} + addend);
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== bench/tb_sprite_animation_sequencer_core.sv =====
// Self-checking testbench for sprite_animation_sequencer_core: a directed table, then
// random phases under several register settings and idle patterns, checked by a predictor.
// Depends on sas_pkg and the sequencer RTL only.
module tb_sprite_animation_sequencer_core;

  localparam logic [1:0]  ACT_UNUSED    = 2'd3;
  localparam int          PLAN_LEN      = 25;
  localparam int          PHASES        = 6;
  localparam int          PHASE_ITEMS   = 315;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          MAX_REPORTS   = 10;
  localparam int unsigned LIMIT_CYCLES  = 1000000;

  typedef struct packed {
    logic [5:0]                   pad;
    logic [sas_pkg::NEXT_W-1:0]   next_set;
    logic [sas_pkg::RSTD_W-1:0]   hold_time;
    logic [sas_pkg::DELAY_W-1:0]  delay;
    logic                         split;
    logic [sas_pkg::FRAME_W-1:0]  stop;
    logic [sas_pkg::FRAME_W-1:0]  start;
    logic [sas_pkg::SETIDX_W-1:0] set_index;
    logic [sas_pkg::TIME_W-1:0]   now;
  } in_word_t;

  typedef struct packed {
    logic                         pad;
    logic                         running;
    logic                         holding;
    logic                         changed;
    logic [sas_pkg::SETIDX_W-1:0] set_now;
    logic [sas_pkg::MASK_W-1:0]   right;
    logic [sas_pkg::MASK_W-1:0]   left;
    logic [sas_pkg::FRAME_W-1:0]  frame;
  } out_word_t;

  typedef struct packed {
    logic        is_cfg;
    logic        typed;
    logic        cfg_reg;
    logic [15:0] cfg_val;
    logic [1:0]  act;
    in_word_t    d;
    out_word_t   want;
  } plan_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [sas_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                     in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [sas_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic                           cfg_index;
  logic [15:0]                    cfg_data;

  sas_pkg::entry_t              desc_mem [sas_pkg::SET_DEPTH_DEF];
  logic [sas_pkg::SETIDX_W-1:0] cur_set = '0;
  logic [sas_pkg::FRAME_W-1:0]  cur_frame = '0;
  logic [sas_pkg::TICK_W-1:0]   tick_cnt = '0;
  logic                         hold_on = 1'b0;
  logic [sas_pkg::TIME_W-1:0]   wake_time = '0;
  logic                         running = 1'b0;
  logic [sas_pkg::WIDTH_W-1:0]  frame_width_q = '0;
  logic [sas_pkg::COUNT_W-1:0]  set_count_q = '0;

  out_word_t   expected_frames [$];
  int          mismatches = 0;
  int          send_gap = 17;
  int          recv_gap = 45;
  logic [31:0] wall = '0;
  int unsigned cycles = 0;

  sprite_animation_sequencer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin : watchdog
    wait (cycles >= LIMIT_CYCLES);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit enter_set(int idx);
    if (idx < 0 || idx >= int'(set_count_q) || idx >= sas_pkg::SET_DEPTH_DEF) return 1'b0;
    cur_set = idx[sas_pkg::SETIDX_W-1:0];
    tick_cnt = '0;
    wake_time = '0;
    cur_frame = desc_mem[idx].start;
    running = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit advance_tick(logic [sas_pkg::TIME_W-1:0] now);
    sas_pkg::entry_t e;
    int unsigned     cnt;
    int unsigned     dly;
    int              nf;
    bit              over;
    if (!running) return 1'b0;
    e = desc_mem[cur_set];
    if (e.start == e.stop && e.next_set[sas_pkg::NEXT_W-1]) return 1'b0;
    if (hold_on && wake_time > now) return 1'b0;
    cnt = tick_cnt + (e.split ? 2 : 1);
    if (cnt > 65535) cnt = 65535;
    tick_cnt = cnt[sas_pkg::TICK_W-1:0];
    dly = (e.delay == 0) ? 1 : e.delay;
    if (e.start < e.stop) begin
      nf = int'(e.start) + int'(cnt / dly);
    end else begin
      nf = int'(e.start) - int'(cnt / dly);
    end
    if (e.split && ((nf % 2) != 0)) nf = nf - 1;
    over = (e.start < e.stop) ? (nf > int'(e.stop)) : (nf < int'(e.stop));
    if (over) begin
      if (!hold_on) begin
        hold_on = 1'b1;
        wake_time = now + e.hold_time;
        return 1'b0;
      end
      hold_on = 1'b0;
      return enter_set(int'($signed(e.next_set)));
    end
    if (nf != int'(cur_frame)) begin
      cur_frame = nf[sas_pkg::FRAME_W-1:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic out_word_t predict_frame(logic [1:0] act, in_word_t d);
    out_word_t   r;
    bit          changed;
    int unsigned left_px;
    int unsigned right_px;
    changed = 1'b0;
    case (act)
      sas_pkg::ACT_TICK: changed = advance_tick(d.now);
      sas_pkg::ACT_SELECT: changed = enter_set(int'(d.set_index));
      sas_pkg::ACT_WRITE: begin
        desc_mem[d.set_index].start = d.start;
        desc_mem[d.set_index].stop = d.stop;
        desc_mem[d.set_index].split = d.split;
        desc_mem[d.set_index].delay = d.delay;
        desc_mem[d.set_index].hold_time = d.hold_time;
        desc_mem[d.set_index].next_set = d.next_set;
      end
      default: ;
    endcase
    left_px = cur_frame * frame_width_q;
    right_px = (cur_frame + 1) * frame_width_q;
    r = '0;
    r.frame = cur_frame;
    r.left = left_px[sas_pkg::MASK_W-1:0];
    r.right = right_px[sas_pkg::MASK_W-1:0];
    r.set_now = cur_set;
    r.changed = changed;
    r.holding = hold_on;
    r.running = running;
    return r;
  endfunction

  function automatic plan_row_t item_row(logic [1:0] act, logic [31:0] now, logic [3:0] idx,
                                         logic [7:0] start, logic [7:0] stop, logic split,
                                         logic [7:0] delay, logic [15:0] rd, logic [4:0] nxt);
    plan_row_t p;
    p = '0;
    p.act = act;
    p.d.now = now;
    p.d.set_index = idx;
    p.d.start = start;
    p.d.stop = stop;
    p.d.split = split;
    p.d.delay = delay;
    p.d.hold_time = rd;
    p.d.next_set = nxt;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(logic r, logic [15:0] v);
    plan_row_t p;
    p = '0;
    p.is_cfg = 1'b1;
    p.cfg_reg = r;
    p.cfg_val = v;
    return p;
  endfunction

  task automatic check_result(out_word_t got);
    out_word_t want;
    if (expected_frames.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("unexpected result %h, none outstanding", got);
      return;
    end
    want = expected_frames.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("mismatch: expected frame %0d left %0d right %0d set %0d chg %b hold %b run %b",
                 want.frame, want.left, want.right, want.set_now, want.changed, want.holding,
                 want.running, " | got frame %0d left %0d right %0d set %0d chg %b hold %b run %b",
                 got.frame, got.left, got.right, got.set_now, got.changed, got.holding,
                 got.running);
      end
    end
  endtask

  initial begin : result_sink
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result(out_tdata);
      out_tready <= ($urandom_range(99) >= recv_gap);
    end
  end

  task automatic send_request(logic [1:0] act, in_word_t d, bit typed, out_word_t want);
    out_word_t p;
    if ($urandom_range(199) == 0) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (expected_frames.size() != 0) @(posedge clk);
    end
    while ($urandom_range(99) < send_gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= act;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = predict_frame(act, d);
    expected_frames.push_back(typed ? want : p);
  endtask

  task automatic write_reg(logic r, logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (r == sas_pkg::REG_FRAME_WIDTH) begin
      frame_width_q = v;
    end else begin
      set_count_q = v[sas_pkg::COUNT_W-1:0];
    end
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic shape_entry(inout in_word_t d);
    int span;
    span = $urandom_range(6);
    d.start = 8'($urandom_range(255));
    if ($urandom_range(1)) begin
      d.stop = (int'(d.start) + span > 255) ? 8'hFF : 8'(int'(d.start) + span);
    end else begin
      d.stop = (int'(d.start) < span) ? 8'h00 : 8'(int'(d.start) - span);
    end
    d.split = 1'($urandom_range(1));
    d.delay = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(3));
    d.hold_time = ($urandom_range(19) == 0) ? 16'($urandom_range(65535)) :
                  16'($urandom_range(6));
    if ($urandom_range(9) < 7) begin
      d.next_set = 5'($urandom_range(15));
    end else if ($urandom_range(1)) begin
      d.next_set = 5'h1F;
    end else begin
      d.next_set = 5'h10 + 5'($urandom_range(15));
    end
  endtask

  task automatic random_request(output logic [1:0] act, output in_word_t d);
    logic [95:0] raw;
    int          r;
    raw = {$urandom, $urandom, $urandom};
    d = raw[sas_pkg::IN_DATA_W-1:0];
    d.pad = '0;
    r = $urandom_range(99);
    if (r < 60) begin
      act = sas_pkg::ACT_TICK;
    end else if (r < 72) begin
      act = sas_pkg::ACT_SELECT;
    end else if (r < 96) begin
      act = sas_pkg::ACT_WRITE;
    end else begin
      act = ACT_UNUSED;
    end
    r = $urandom_range(99);
    if (r < 2) begin
      wall = $urandom;
    end else if (r < 3) begin
      wall = 32'hFFFF_FFF0 + $urandom_range(15);
    end else begin
      wall = wall + $urandom_range(3);
    end
    if (act == sas_pkg::ACT_TICK) d.now = wall;
    if (act == sas_pkg::ACT_WRITE && $urandom_range(99) >= 15) shape_entry(d);
  endtask

  initial begin : main_seq
    plan_row_t   plan [PLAN_LEN];
    in_word_t    d;
    logic [1:0]  act;
    logic [15:0] fw;
    logic [4:0]  sc;
    int          ph;
    int          n;
    int          k;

    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= sas_pkg::ACT_TICK;
    cfg_valid <= 1'b0;
    cfg_index <= sas_pkg::REG_FRAME_WIDTH;
    cfg_data <= '0;
    rst_n <= 1'b0;

    plan[0]  = item_row(sas_pkg::ACT_TICK, 32'd0, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[1]  = item_row(sas_pkg::ACT_SELECT, 32'd0, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[2]  = item_row(ACT_UNUSED, 32'hFFFF_FFFF, 4'hF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 16'hFFFF,
                        5'h1F);
    plan[3]  = item_row(sas_pkg::ACT_WRITE, 32'd0, 4'd0, 8'd2, 8'd5, 1'b0, 8'd0, 16'd3, 5'd1);
    plan[4]  = item_row(sas_pkg::ACT_WRITE, 32'd0, 4'd1, 8'd255, 8'd255, 1'b0, 8'd255,
                        16'hFFFF, 5'h1F);
    plan[5]  = item_row(sas_pkg::ACT_WRITE, 32'd0, 4'd2, 8'd10, 8'd0, 1'b1, 8'd1, 16'd0, 5'd0);
    plan[6]  = item_row(sas_pkg::ACT_WRITE, 32'd0, 4'd3, 8'd0, 8'd255, 1'b1, 8'd255,
                        16'hFFFF, 5'd2);
    plan[7]  = cfg_row(sas_pkg::REG_FRAME_WIDTH, 16'hFFFF);
    plan[8]  = cfg_row(sas_pkg::REG_SET_COUNT, 16'd4);
    plan[9]  = item_row(sas_pkg::ACT_TICK, 32'd5, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[10] = item_row(sas_pkg::ACT_SELECT, 32'd0, 4'd1, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[11] = item_row(sas_pkg::ACT_TICK, 32'd7, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[12] = item_row(sas_pkg::ACT_SELECT, 32'd0, 4'd7, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[13] = item_row(sas_pkg::ACT_SELECT, 32'd0, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[14] = item_row(sas_pkg::ACT_TICK, 32'd100, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[15] = item_row(sas_pkg::ACT_TICK, 32'd101, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[16] = item_row(sas_pkg::ACT_TICK, 32'd102, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[17] = item_row(sas_pkg::ACT_TICK, 32'd103, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[18] = item_row(sas_pkg::ACT_TICK, 32'd105, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[19] = item_row(sas_pkg::ACT_TICK, 32'd106, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[20] = item_row(sas_pkg::ACT_SELECT, 32'd0, 4'd2, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[21] = item_row(sas_pkg::ACT_TICK, 32'd0, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[22] = item_row(sas_pkg::ACT_SELECT, 32'd0, 4'd3, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0, 5'd0);
    plan[23] = item_row(sas_pkg::ACT_TICK, 32'hFFFF_FFFE, 4'd0, 8'd0, 8'd0, 1'b0, 8'd0, 16'd0,
                        5'd0);
    plan[24] = item_row(sas_pkg::ACT_WRITE, 32'd0, 4'd3, 8'd255, 8'd0, 1'b1, 8'd0, 16'hFFFF,
                        5'h10);
    for (k = 0; k < 5; k++) plan[k].typed = 1'b1;
    plan[10].typed = 1'b1;
    plan[10].want.frame = 8'd255;
    plan[10].want.left = 24'hFEFF01;
    plan[10].want.right = 24'hFFFF00;
    plan[10].want.set_now = 4'd1;
    plan[10].want.changed = 1'b1;
    plan[10].want.running = 1'b1;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < PLAN_LEN; k++) begin
      if (plan[k].is_cfg) begin
        settle();
        write_reg(plan[k].cfg_reg, plan[k].cfg_val);
        cfg_valid <= 1'b0;
      end else begin
        send_request(plan[k].act, plan[k].d, plan[k].typed, plan[k].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      fw = 16'($urandom_range(65535));
      case (ph)
        0: sc = 5'd16;
        1: begin
          fw = 16'hFFFF;
          sc = 5'd16;
        end
        2: begin
          fw = 16'd0;
          sc = 5'd0;
        end
        3: begin
          fw = 16'd1;
          sc = 5'd1;
        end
        4: sc = 5'($urandom_range(16));
        default: sc = 5'd16;
      endcase
      send_gap = (ph < 2) ? 17 : (ph < 4) ? 45 : 0;
      recv_gap = (ph < 2) ? 45 : (ph < 4) ? 17 : 0;
      write_reg(sas_pkg::REG_FRAME_WIDTH, fw);
      write_reg(sas_pkg::REG_SET_COUNT, {11'd0, sc});
      cfg_valid <= 1'b0;
      // Every descriptor is filled before any random request can select or chain to it.
      if (ph == 0) begin
        for (k = 0; k < sas_pkg::SET_DEPTH_DEF; k++) begin
          random_request(act, d);
          shape_entry(d);
          d.set_index = k[sas_pkg::SETIDX_W-1:0];
          send_request(sas_pkg::ACT_WRITE, d, 1'b0, '0);
        end
      end
      for (n = 0; n < PHASE_ITEMS; n++) begin
        random_request(act, d);
        send_request(act, d, 1'b0, '0);
      end
    end

    settle();
    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
